// ===== sv/mbr_pkg.sv =====
// Shared types and constants of the masked bilinear resampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package mbr_pkg;
   // Fixed field widths
   localparam int IDX_W    = 14;
   localparam int TEMP_W   = 22;
   localparam int MASK_W   = 9;
   localparam int COORD_W  = 24;
   localparam int ADDR_W   = 20;   // wide enough for 1024 x 1024 grids
   localparam int WT_W     = 33;   // corner weight, Q0.32, up to 1.0
   localparam int NUM_W    = 58;   // weighted sum plus rounding term
   localparam int DEN_W    = 35;
   localparam int QUO_W    = 22;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SP_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SP_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COLS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_T_LOWER  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_T_UPPER  = 3'd7;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [MASK_W-1:0] MASK_HALF  = 9'd128;
   localparam logic [DEN_W-1:0]  WEIGHT_MIN = 35'd43;

   // Grid geometry seen by the front end
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [23:0]               inv_x;
      logic [23:0]               inv_y;
      logic [7:0]                cols;
      logic [7:0]                rows;
   } mbr_geom_type;

   // Temperature window seen by the back end
   typedef struct packed {
      logic [TEMP_W-1:0] lower;
      logic [TEMP_W-1:0] upper;
   } mbr_bounds_type;

   // One word in the queue between front and back
   typedef struct packed {
      logic                         op;
      logic [IDX_W-1:0]             load_idx;
      logic [TEMP_W-1:0]            load_temp;
      logic [MASK_W-1:0]            load_mask;
      logic [3:0][ADDR_W-1:0]       addr;
      logic [3:0][WT_W-1:0]         wt;
   } mbr_item_type;

   // Queue status
   typedef struct packed {
      logic [3:0] count;
      logic       full;
      logic       empty;
   } mbr_qstat_type;
endpackage
`default_nettype wire

// ===== sv/mbr_front.sv =====
// Front end: takes words, forms corner addresses and bilinear weights.
// Depends on mbr_pkg.
`default_nettype none
module mbr_front import mbr_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic                      in_op,
   input  wire logic [IDX_W-1:0]          in_idx,
   input  wire logic [TEMP_W-1:0]         in_temp,
   input  wire logic [MASK_W-1:0]         in_mask,
   input  wire logic signed [COORD_W-1:0] in_x,
   input  wire logic signed [COORD_W-1:0] in_y,
   input  wire mbr_geom_type              geom,
   output logic                           push,
   output mbr_item_type                   push_item
);
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int XW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
   localparam int YW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;

   // Clamp a signed corner index into [0, lim]
   function automatic logic [17:0] clamp_idx(logic signed [17:0] c, logic [17:0] lim);
      logic [17:0] r;
      if (c[17])
         r = '0;
      else if (c > $signed(lim))
         r = lim;
      else
         r = c;
      return r;
   endfunction

   // Effective grid size
   logic [CW-1:0] nx;
   logic [RW-1:0] ny;
   always_comb begin
      if (geom.cols == 8'd0)
         nx = CW'(1);
      else if (32'(geom.cols) > MAX_COLS)
         nx = CW'(MAX_COLS);
      else
         nx = CW'(geom.cols);
      if (geom.rows == 8'd0)
         ny = RW'(1);
      else if (32'(geom.rows) > MAX_ROWS)
         ny = RW'(MAX_ROWS);
      else
         ny = RW'(geom.rows);
   end

   // Stage 1: offset from origin
   logic                     s1_valid_ff, s1_op_ff;
   logic [IDX_W-1:0]         s1_idx_ff;
   logic [TEMP_W-1:0]        s1_temp_ff;
   logic [MASK_W-1:0]        s1_mask_ff;
   logic signed [24:0]       s1_dx_ff, s1_dy_ff;
   // Stage 2: fractional index, Q.32
   logic                     s2_valid_ff, s2_op_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic [TEMP_W-1:0]        s2_temp_ff;
   logic [MASK_W-1:0]        s2_mask_ff;
   logic signed [48:0]       s2_px_ff, s2_py_ff;
   // Stage 3: clamped corners and axis weights
   logic                     s3_valid_ff, s3_op_ff;
   logic [IDX_W-1:0]         s3_idx_ff;
   logic [TEMP_W-1:0]        s3_temp_ff;
   logic [MASK_W-1:0]        s3_mask_ff;
   logic [XW-1:0]            s3_i0_ff, s3_i1_ff;
   logic [YW-1:0]            s3_j0_ff, s3_j1_ff;
   logic [16:0]              s3_wx0_ff, s3_wx1_ff, s3_wy0_ff, s3_wy1_ff;
   // Stage 4: queue word
   logic                     s4_valid_ff;
   mbr_item_type             s4_item_ff;

   logic signed [49:0] px_in, py_in;
   logic signed [17:0] bx0, bx1, by0, by1;
   logic [17:0]        cx0, cx1, cy0, cy1, limx, limy;
   logic [ADDR_W-1:0]  i0e, i1e, j0e, j1e, nxe;
   mbr_item_type       s4_item_in;

   always_comb begin
      px_in = s1_dx_ff * $signed({1'b0, geom.inv_x});
      py_in = s1_dy_ff * $signed({1'b0, geom.inv_y});
      // Floor is the arithmetic shift by 32
      bx0  = 18'($signed(s2_px_ff[48:32]));
      by0  = 18'($signed(s2_py_ff[48:32]));
      bx1  = bx0 + 18'sd1;
      by1  = by0 + 18'sd1;
      limx = 18'(nx) - 18'd1;
      limy = 18'(ny) - 18'd1;
      cx0  = clamp_idx(bx0, limx);
      cx1  = clamp_idx(bx1, limx);
      cy0  = clamp_idx(by0, limy);
      cy1  = clamp_idx(by1, limy);
      // Linear addresses and corner weights
      i0e  = ADDR_W'(s3_i0_ff);
      i1e  = ADDR_W'(s3_i1_ff);
      j0e  = ADDR_W'(s3_j0_ff);
      j1e  = ADDR_W'(s3_j1_ff);
      nxe  = ADDR_W'(nx);
      s4_item_in.op        = s3_op_ff;
      s4_item_in.load_idx  = s3_idx_ff;
      s4_item_in.load_temp = s3_temp_ff;
      s4_item_in.load_mask = s3_mask_ff;
      s4_item_in.addr[0]   = j0e * nxe + i0e;
      s4_item_in.addr[1]   = j0e * nxe + i1e;
      s4_item_in.addr[2]   = j1e * nxe + i0e;
      s4_item_in.addr[3]   = j1e * nxe + i1e;
      s4_item_in.wt[0]     = WT_W'(s3_wx0_ff * s3_wy0_ff);
      s4_item_in.wt[1]     = WT_W'(s3_wx1_ff * s3_wy0_ff);
      s4_item_in.wt[2]     = WT_W'(s3_wx0_ff * s3_wy1_ff);
      s4_item_in.wt[3]     = WT_W'(s3_wx1_ff * s3_wy1_ff);
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      s1_op_ff   <= in_op;
      s1_idx_ff  <= in_idx;
      s1_temp_ff <= in_temp;
      s1_mask_ff <= in_mask;
      s1_dx_ff   <= 25'(in_x) - 25'(geom.origin_x);
      s1_dy_ff   <= 25'(in_y) - 25'(geom.origin_y);

      s2_op_ff   <= s1_op_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_temp_ff <= s1_temp_ff;
      s2_mask_ff <= s1_mask_ff;
      s2_px_ff   <= px_in[48:0];
      s2_py_ff   <= py_in[48:0];

      s3_op_ff   <= s2_op_ff;
      s3_idx_ff  <= s2_idx_ff;
      s3_temp_ff <= s2_temp_ff;
      s3_mask_ff <= s2_mask_ff;
      s3_i0_ff   <= cx0[XW-1:0];
      s3_i1_ff   <= cx1[XW-1:0];
      s3_j0_ff   <= cy0[YW-1:0];
      s3_j1_ff   <= cy1[YW-1:0];
      s3_wx0_ff  <= 17'h10000 - {1'b0, s2_px_ff[31:16]};
      s3_wx1_ff  <= {1'b0, s2_px_ff[31:16]};
      s3_wy0_ff  <= 17'h10000 - {1'b0, s2_py_ff[31:16]};
      s3_wy1_ff  <= {1'b0, s2_py_ff[31:16]};

      s4_item_ff <= s4_item_in;
   end

   assign push      = s4_valid_ff;
   assign push_item = s4_item_ff;
endmodule
`default_nettype wire

// ===== sv/mbr_queue.sv =====
// Short queue of words between the front and back ends.
// Depends on mbr_pkg.
`default_nettype none
module mbr_queue import mbr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mbr_item_type  push_item,
   input  wire logic          pop,
   output mbr_item_type       head,
   output mbr_qstat_type      stat
);
   localparam int DEPTH = 8;
   localparam int PW    = $clog2(DEPTH);

   mbr_item_type   slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]    count_ff;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.count = 4'(count_ff);
   assign stat.full  = (count_ff == (PW+1)'(DEPTH));
   assign stat.empty = (count_ff == '0);
endmodule
`default_nettype wire

// ===== sv/mbr_back.sv =====
// Back end: sample store in four banks, corner qualification, weighted sums.
// Depends on mbr_pkg.
`default_nettype none
module mbr_back import mbr_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pop,
   input  wire mbr_item_type   item,
   input  wire mbr_bounds_type bounds,
   output logic                sum_valid,
   output logic [NUM_W-1:0]    sum_num,
   output logic [DEN_W-1:0]    sum_den
);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = TEMP_W + MASK_W;

   logic [31:0] widx;
   logic        wr_en;
   assign widx  = 32'(item.load_idx);
   assign wr_en = pop && (item.op == OP_LOAD) && (widx < 32'(DEPTH));

   // Four copies of the store, one read port each
   logic [SW-1:0] rd_ff [4];
   genvar k;
   generate
      for (k = 0; k < 4; k++) begin : g_bank
         logic [SW-1:0] mem [DEPTH];
         always_ff @(posedge clock) begin
            if (wr_en)
               mem[widx[AW-1:0]] <= {item.load_mask, item.load_temp};
            rd_ff[k] <= mem[item.addr[k][AW-1:0]];
         end
      end
   endgenerate

   logic                   b1_valid_ff, b2_valid_ff, b3_valid_ff;
   logic [3:0][WT_W-1:0]   b1_wt_ff, b2_wt_ff;
   logic [3:0][54:0]       b2_prod_ff;
   logic [NUM_W-1:0]       b3_num_ff;
   logic [DEN_W-1:0]       b3_den_ff;

   logic [3:0][WT_W-1:0]   qual_wt;
   logic [3:0][54:0]       prod;
   logic [TEMP_W-1:0]      t [4];
   logic [MASK_W-1:0]      m [4];

   // Qualify corners and weight temperatures
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t[i] = rd_ff[i][TEMP_W-1:0];
         m[i] = rd_ff[i][SW-1:TEMP_W];
         if (m[i] < MASK_HALF && t[i] > bounds.lower && t[i] < bounds.upper)
            qual_wt[i] = b1_wt_ff[i];
         else
            qual_wt[i] = '0;
         prod[i] = 55'(qual_wt[i]) * 55'(t[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= pop && (item.op == OP_QUERY);
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_wt_ff   <= item.wt;
      b2_wt_ff   <= qual_wt;
      b2_prod_ff <= prod;
      // Sum the four corners
      b3_num_ff  <= NUM_W'(b2_prod_ff[0]) + NUM_W'(b2_prod_ff[1])
                  + NUM_W'(b2_prod_ff[2]) + NUM_W'(b2_prod_ff[3]);
      b3_den_ff  <= DEN_W'(b2_wt_ff[0]) + DEN_W'(b2_wt_ff[1])
                  + DEN_W'(b2_wt_ff[2]) + DEN_W'(b2_wt_ff[3]);
   end

   assign sum_valid = b3_valid_ff;
   assign sum_num   = b3_num_ff;
   assign sum_den   = b3_den_ff;
endmodule
`default_nettype wire

// ===== sv/mbr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round half up.
// Depends on mbr_pkg.
`default_nettype none
module mbr_div import mbr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      out_quo,
   output logic                  out_flag
);
   localparam int NS = QUO_W + 1;

   logic                   v_ff   [NS];
   logic                   flg_ff [NS];
   logic [NUM_W-1:0]       rem_ff [NS];
   logic [DEN_W-1:0]       den_ff [NS];
   logic [QUO_W-1:0]       quo_ff [NS];

   // Entry stage: add half the divisor, flag tiny weight
   always_ff @(posedge clock) begin
      if (reset)
         v_ff[0] <= 1'b0;
      else
         v_ff[0] <= in_valid;
      rem_ff[0] <= in_num + NUM_W'(in_den >> 1);
      den_ff[0] <= in_den;
      flg_ff[0] <= (in_den < WEIGHT_MIN);
      quo_ff[0] <= '0;
   end

   genvar s;
   generate
      for (s = 1; s < NS; s++) begin : g_stage
         localparam int B = QUO_W - s;
         logic [NUM_W-1:0] shd;
         logic             ge;
         assign shd = NUM_W'(den_ff[s-1]) << B;
         assign ge  = (rem_ff[s-1] >= shd);
         always_ff @(posedge clock) begin
            if (reset)
               v_ff[s] <= 1'b0;
            else
               v_ff[s] <= v_ff[s-1];
            rem_ff[s] <= ge ? (rem_ff[s-1] - shd) : rem_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            flg_ff[s] <= flg_ff[s-1];
            quo_ff[s] <= quo_ff[s-1] | (QUO_W'(ge) << B);
         end
      end
   endgenerate

   assign out_valid = v_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_flag  = flg_ff[NS-1];
endmodule
`default_nettype wire

// ===== sv/masked_bilinear_resampler.sv =====
// Masked bilinear resampler: a load word (req_op 0) writes one grid sample,
// a query word (req_op 1) yields one result strobe on rsp_valid, which the
// receiver must take in that cycle. One word is accepted per cycle while busy
// is low; a query's result passes through the 4-stage front end, the queue
// register, the 3-stage lookup and sum path and the 23-stage divider.
// busy rises only if the queue between front and back holds four words or more.
// The sample store has no reset; read only samples that were loaded.
`default_nettype none
module masked_bilinear_resampler import mbr_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_op,
   input  wire logic [IDX_W-1:0]          req_sample_index,
   input  wire logic [TEMP_W-1:0]         req_sample_temp,
   input  wire logic [MASK_W-1:0]         req_sample_mask,
   input  wire logic signed [COORD_W-1:0] req_query_x,
   input  wire logic signed [COORD_W-1:0] req_query_y,
   output logic                           rsp_valid,
   output logic [TEMP_W-1:0]              rsp_interp_temp,
   output logic                           rsp_no_valid_corner,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_W-1:0]          csr_wdata
);
   // Configuration registers
   mbr_geom_type   geom_ff;
   mbr_bounds_type bounds_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.origin_x <= '0;
         geom_ff.origin_y <= '0;
         geom_ff.inv_x    <= 24'd65536;
         geom_ff.inv_y    <= 24'd65536;
         geom_ff.cols     <= 8'd128;
         geom_ff.rows     <= 8'd128;
         bounds_ff.lower  <= 22'd69376;
         bounds_ff.upper  <= 22'd78080;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: geom_ff.origin_x <= csr_wdata;
            REG_ORIGIN_Y: geom_ff.origin_y <= csr_wdata;
            REG_INV_SP_X: geom_ff.inv_x    <= csr_wdata;
            REG_INV_SP_Y: geom_ff.inv_y    <= csr_wdata;
            REG_COLS:     geom_ff.cols     <= csr_wdata[7:0];
            REG_ROWS:     geom_ff.rows     <= csr_wdata[7:0];
            REG_T_LOWER:  bounds_ff.lower  <= csr_wdata[TEMP_W-1:0];
            REG_T_UPPER:  bounds_ff.upper  <= csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   logic          accept, push, pop;
   mbr_item_type  push_item, head;
   mbr_qstat_type qstat;

   assign accept = start && !busy;
   // Four words may still be in the front end when busy rises
   assign busy   = (qstat.count >= 4'd4);
   assign pop    = !qstat.empty;

   mbr_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock, .reset,
      .in_valid (accept),
      .in_op    (req_op),
      .in_idx   (req_sample_index),
      .in_temp  (req_sample_temp),
      .in_mask  (req_sample_mask),
      .in_x     (req_query_x),
      .in_y     (req_query_y),
      .geom     (geom_ff),
      .push, .push_item
   );

   mbr_queue u_queue (
      .clock, .reset, .push, .push_item, .pop, .head, .stat(qstat)
   );

   logic             sum_valid;
   logic [NUM_W-1:0] sum_num;
   logic [DEN_W-1:0] sum_den;
   mbr_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock, .reset, .pop, .item(head), .bounds(bounds_ff),
      .sum_valid, .sum_num, .sum_den
   );

   logic             div_valid, div_flag;
   logic [QUO_W-1:0] div_quo;
   mbr_div u_div (
      .clock, .reset,
      .in_valid (sum_valid),
      .in_num   (sum_num),
      .in_den   (sum_den),
      .out_valid(div_valid),
      .out_quo  (div_quo),
      .out_flag (div_flag)
   );

   // Result word
   assign rsp_valid           = div_valid;
   assign rsp_interp_temp     = div_flag ? '0 : div_quo;
   assign rsp_no_valid_corner = div_flag;

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full && !pop))
      else $error("queue overflow");
   a_busy_level: assert property (@(posedge clock) disable iff (reset)
      busy |-> (qstat.count >= 4'd4) && !qstat.empty)
      else $error("busy without queue backlog");
   a_quiet_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");
endmodule
`default_nettype wire

// ===== sim/masked_bilinear_resampler_tb.sv =====
// Testbench for masked_bilinear_resampler: loads grids, sends queries and
// checks every result against a bit-true predictor in a scoreboard class.
// Depends on mbr_pkg (sv/mbr_pkg.sv) and the resampler RTL.
`timescale 1ns / 1ps
module masked_bilinear_resampler_tb;
   import mbr_pkg::*;

   localparam int GRID_DEPTH = 128 * 128;
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT = 4000;

   // Predictor and store of expected results
   class resample_scoreboard;
      typedef struct {
         logic [TEMP_W-1:0] temp;
         logic              flag;
      } interp_result_type;

      interp_result_type expected_q[$];
      int errors;
      logic signed [COORD_W-1:0] org_x, org_y;
      logic [23:0] inv_x, inv_y;
      logic [7:0] cols, rows;
      logic [TEMP_W-1:0] t_lo, t_hi;
      logic [30:0] grid [GRID_DEPTH];

      function new();
         errors = 0;
         org_x = 0;
         org_y = 0;
         inv_x = 24'd65536;
         inv_y = 24'd65536;
         cols = 8'd128;
         rows = 8'd128;
         t_lo = 22'd69376;
         t_hi = 22'd78080;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         case (idx)
            REG_ORIGIN_X: org_x = v;
            REG_ORIGIN_Y: org_y = v;
            REG_INV_SP_X: inv_x = v;
            REG_INV_SP_Y: inv_y = v;
            REG_COLS:     cols = v[7:0];
            REG_ROWS:     rows = v[7:0];
            REG_T_LOWER:  t_lo = v[TEMP_W-1:0];
            REG_T_UPPER:  t_hi = v[TEMP_W-1:0];
            default: ;
         endcase
      endfunction

      function longint grid_dim(logic [7:0] v);
         if (v == 0) return 1;
         if (v > 128) return 128;
         return v;
      endfunction

      // floor of the Q.32 index and its 16-bit fraction
      function void split_axis(logic signed [COORD_W-1:0] coord,
                               logic signed [COORD_W-1:0] org, logic [23:0] inv,
                               output longint base, output longint frac);
         longint p;
         p = (longint'(coord) - longint'(org)) * longint'(inv);
         base = p >>> 32;
         frac = p[31:16];
      endfunction

      function longint clamp_axis(longint c, longint n);
         if (c < 0) return 0;
         if (c > n - 1) return n - 1;
         return c;
      endfunction

      function void note_word(logic op, logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] temp,
                              logic [MASK_W-1:0] mask, logic signed [COORD_W-1:0] qx,
                              logic signed [COORD_W-1:0] qy);
         longint nx, ny, bx, by, fx, fy, ii, jj, wx, wy;
         longint unsigned num, den, w;
         logic [30:0] e;
         interp_result_type r;
         if (op == OP_LOAD) begin
            grid[idx] = {mask, temp};
            return;
         end
         nx = grid_dim(cols);
         ny = grid_dim(rows);
         split_axis(qx, org_x, inv_x, bx, fx);
         split_axis(qy, org_y, inv_y, by, fy);
         num = 0;
         den = 0;
         for (int dj = 0; dj < 2; dj++) begin
            jj = clamp_axis(by + dj, ny);
            wy = dj ? fy : 65536 - fy;
            for (int di = 0; di < 2; di++) begin
               ii = clamp_axis(bx + di, nx);
               wx = di ? fx : 65536 - fx;
               e = grid[(jj * nx + ii) % GRID_DEPTH];
               // corner counts only when water and strictly inside the window
               if (e[30:22] < MASK_HALF && e[21:0] > t_lo && e[21:0] < t_hi) begin
                  w = wx * wy;
                  num += w * e[21:0];
                  den += w;
               end
            end
         end
         if (den < WEIGHT_MIN) begin
            r.temp = 0;
            r.flag = 1'b1;
         end else begin
            r.temp = TEMP_W'((num + den / 2) / den);
            r.flag = 1'b0;
         end
         expected_q = {expected_q, r};
      endfunction

      function void check_result(logic [TEMP_W-1:0] temp, logic flag);
         interp_result_type r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result temp %0d flag %0d", $time, temp, flag);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (temp !== r.temp) begin
            $display("%0t: interp_temp expected %0d actual %0d", $time, r.temp, temp);
            errors++;
         end
         if (flag !== r.flag) begin
            $display("%0t: no_valid_corner expected %0d actual %0d", $time, r.flag, flag);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   wire  busy;
   logic req_op;
   logic [IDX_W-1:0] req_sample_index;
   logic [TEMP_W-1:0] req_sample_temp;
   logic [MASK_W-1:0] req_sample_mask;
   logic signed [COORD_W-1:0] req_query_x;
   logic signed [COORD_W-1:0] req_query_y;
   wire  rsp_valid;
   wire  [TEMP_W-1:0] rsp_interp_temp;
   wire  rsp_no_valid_corner;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   resample_scoreboard sb;
   bit steady;
   int stall_cycles;

   masked_bilinear_resampler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_sample_index(req_sample_index),
      .req_sample_temp(req_sample_temp), .req_sample_mask(req_sample_mask),
      .req_query_x(req_query_x), .req_query_y(req_query_y),
      .rsp_valid(rsp_valid), .rsp_interp_temp(rsp_interp_temp),
      .rsp_no_valid_corner(rsp_no_valid_corner),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_interp_temp, rsp_no_valid_corner);
         if (rsp_valid || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // One word; random idle cycles before it unless in the steady stretch
   task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] temp,
                            logic [MASK_W-1:0] mask, logic signed [COORD_W-1:0] qx,
                            logic signed [COORD_W-1:0] qy);
      if (!steady && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_op <= op;
      req_sample_index <= idx;
      req_sample_temp <= temp;
      req_sample_mask <= mask;
      req_query_x <= qx;
      req_query_y <= qy;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_word(op, idx, temp, mask, qx, qy);
   endtask

   task automatic load_word(logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] temp,
                            logic [MASK_W-1:0] mask);
      send_word(OP_LOAD, idx, temp, mask, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic query_word(logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qy);
      send_word(OP_QUERY, IDX_W'($urandom), TEMP_W'($urandom), MASK_W'($urandom), qx, qy);
   endtask

   // Let the block drain, then write all registers
   task automatic configure(logic [CSR_W-1:0] v [8]);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.write_reg(CSR_IDX_W'(i), v[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [TEMP_W-1:0] pick_temp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return TEMP_W'($urandom);
      if (r < 22) return sb.t_lo;
      if (r < 30) return sb.t_hi;
      if (sb.t_hi > sb.t_lo + 1) return TEMP_W'($urandom_range(sb.t_lo + 1, sb.t_hi - 1));
      return TEMP_W'($urandom);
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask();
      if ($urandom_range(0, 99) < 60) return MASK_W'($urandom_range(0, 127));
      return MASK_W'($urandom_range(128, 256));
   endfunction

   // Coordinate mostly near the grid in use, sometimes anywhere
   function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] org,
                                                           logic [23:0] inv, longint n);
      longint unsigned span, off;
      longint c;
      if ($urandom_range(0, 99) < 20) return COORD_W'($urandom);
      span = ((n + 1) << 32) / inv + 1;
      off = {$urandom, $urandom} % (span + span / 4);
      c = longint'(org) - longint'(span / 8) + longint'(off);
      if (c > 8388607) c = 8388607;
      if (c < -8388608) c = -8388608;
      return COORD_W'(c);
   endfunction

   task automatic load_grid();
      longint n;
      n = sb.grid_dim(sb.cols) * sb.grid_dim(sb.rows);
      for (longint i = 0; i < n; i++) load_word(IDX_W'(i), pick_temp(), pick_mask());
   endtask

   initial begin
      logic [CSR_W-1:0] cfg [8];
      logic [CSR_W-1:0] plan [7][8];
      longint nx, ny;
      int count;

      sb = new();
      steady = 0;
      stall_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_LOAD;
      req_sample_index <= '0;
      req_sample_temp <= '0;
      req_sample_mask <= '0;
      req_query_x <= '0;
      req_query_y <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 2x2 grid, one index unit per 65536 coordinate LSBs
      cfg = '{24'd0, 24'd0, 24'd65536, 24'd65536, 24'd2, 24'd2, 24'd69376, 24'd78080};
      configure(cfg);
      load_word(0, 22'd72000, 9'd256);       // land
      load_word(1, 22'd69376, 9'd0);         // at lower bound, excluded
      load_word(2, 22'd78080, 9'd0);         // at upper bound, excluded
      load_word(3, 22'd72000, 9'd127);       // water just below half
      query_word(24'sd1, 24'sd1);            // tiny weight on the only valid corner
      query_word(24'sh008000, 24'sh008000);  // center of the cell
      query_word(-24'sd8388608, -24'sd8388608);
      query_word(24'sd8388607, 24'sd8388607);
      load_word(0, 22'd75000, 9'd128);       // exactly half is land
      load_word(1, 22'd69377, 9'd0);
      load_word(2, 22'd78079, 9'd1);
      query_word(24'sh004000, 24'sh00C000);
      query_word(24'sh00FFFF, 24'sd0);
      query_word(-24'sd1, 24'sh000100);
      load_word(0, 22'd4194303, 9'd0);
      load_word(16383, 22'd0, 9'd256);       // highest index, outside the grid
      query_word(24'sd0, 24'sd0);
      query_word(24'sh007FFF, 24'sh000080);

      // origin_x, origin_y, inv_x, inv_y, cols, rows, lower, upper
      plan[0] = '{24'd0, 24'd0, 24'd65536, 24'd65536, 24'd8, 24'd6, 24'd69376, 24'd78080};
      plan[1] = '{24'h800000, 24'h7FFFFF, 24'd16777215, 24'd1, 24'd128, 24'd2,
                  24'd0, 24'd4194303};
      plan[2] = '{24'h7FFFFF, 24'h800000, 24'd1, 24'd16777215, 24'd0, 24'd255,
                  24'd1000, 24'd3000000};
      plan[3] = '{24'hFFF000, 24'h000800, 24'd300000, 24'd40000, 24'd5, 24'd7,
                  24'd70000, 24'd70000};
      plan[4] = '{24'h001234, 24'hFFFF00, 24'd1200000, 24'd900000, 24'd2, 24'd3,
                  24'd60000, 24'd90000};
      plan[5] = '{24'h000000, 24'h000000, 24'd2000000, 24'd2000000, 24'd4, 24'd4,
                  24'd69376, 24'd78080};
      plan[6] = '{24'hFF8000, 24'h003000, 24'd500000, 24'd700000, 24'd10, 24'd9,
                  24'd65000, 24'd80000};
      count = 0;
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 6) plan[ph][0] = CSR_W'($urandom);
         cfg = plan[ph];
         configure(cfg);
         load_grid();
         nx = sb.grid_dim(sb.cols);
         ny = sb.grid_dim(sb.rows);
         for (int k = 0; k < 40; k++) begin
            steady = (count >= 100 && count < 200);
            count++;
            case ($urandom_range(0, 9))
               0: load_word(IDX_W'($urandom), pick_temp(), pick_mask());
               1, 2: load_word(IDX_W'($urandom_range(0, 32'(nx * ny - 1))),
                               pick_temp(), pick_mask());
               default: query_word(pick_coord(sb.org_x, sb.inv_x, nx),
                                   pick_coord(sb.org_y, sb.inv_y, ny));
            endcase
         end
      end
      steady = 0;

      // Drain
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/mbr_pkg.sv
sv/mbr_front.sv
sv/mbr_queue.sv
sv/mbr_back.sv
sv/mbr_div.sv
sv/masked_bilinear_resampler.sv
sim/masked_bilinear_resampler_tb.sv
